>>> sv/lcop_pkg.sv
// lcop_pkg: shared constants, types and codes for the lipid chain order parameter block
// no dependencies; the design files refer to it by scoped names and the bench imports it
package lcop_pkg;

  // accumulator table geometry
  localparam int unsigned MAX_POSITIONS = 64;
  localparam int unsigned ACC_DEPTH     = 2 * MAX_POSITIONS;
  localparam int unsigned IDX_W         = $clog2(ACC_DEPTH);

  // datapath widths
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned AXIS_W   = 2;
  localparam int unsigned WIDE_W   = 50;
  localparam int unsigned NARROW_W = 24;
  localparam int unsigned OPND_W   = 25;
  localparam int unsigned PROD_W   = 2 * OPND_W;
  localparam int unsigned SQ_W     = 48;
  localparam int unsigned RATIO_W  = 17;
  localparam int unsigned P2_W     = 19;
  localparam int unsigned ORDER_W  = 16;
  localparam int unsigned SQR_W    = 32;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned SUMSQ_W  = 48;
  localparam int unsigned STEP_W   = 3;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [WIDE_W-1:0]   wide_t;
  typedef logic signed [NARROW_W-1:0] narrow_t;
  typedef logic signed [OPND_W-1:0]   opnd_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic [SQ_W-1:0]            sq_t;
  typedef logic [RATIO_W-1:0]         ratio_t;
  typedef logic signed [P2_W-1:0]     p2_t;
  typedef logic signed [ORDER_W-1:0]  order_t;
  typedef logic [SQR_W-1:0]           sqr_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [SUMSQ_W-1:0]         sumsq_t;
  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic [AXIS_W-1:0]          axis_t;

  // projection axis codes
  localparam axis_t AXIS_X     = 2'd0;
  localparam axis_t AXIS_Y     = 2'd1;
  localparam axis_t AXIS_Z     = 2'd2;
  localparam axis_t AXIS_RESET = AXIS_Z;

  // weights 0.6667 and 0.333 in Q16
  localparam opnd_t K_X = 25'sd43693;
  localparam opnd_t K_Y = 25'sd21823;

  // shared multiplier accumulate codes
  typedef enum logic [1:0] {
    MAC_NONE,
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_CROSS,
    ST_NORM,
    ST_DIV,
    ST_TERM,
    ST_ACC,
    ST_DONE
  } state_e;

  // frame vector being worked on
  typedef enum logic [2:0] {
    VS_SZ,
    VS_FWD,
    VS_BCK,
    VS_SX,
    VS_SY
  } vsel_e;

  // accumulator update request and response
  typedef struct packed {
    logic   start;
    logic   in_range;
    idx_t   idx;
    order_t s;
    sqr_t   sq;
  } acc_req_t;

  typedef struct packed {
    logic   done;
    sum_t   sum;
    sumsq_t sumsq;
  } acc_rsp_t;

endpackage

>>> sv/lcop_mac.sv
// lcop_mac: shared signed multiplier with a registered product and an accumulator
// depends on lcop_pkg
module lcop_mac (
  input  logic              clk_i,
  input  lcop_pkg::mac_op_e op_i,
  input  lcop_pkg::opnd_t   a_i,
  input  lcop_pkg::opnd_t   b_i,
  output lcop_pkg::prod_t   prod_o,
  output lcop_pkg::prod_t   acc_o
);

  lcop_pkg::prod_t prod_q;
  lcop_pkg::prod_t acc_q, acc_d;

  // accumulate the product registered in the previous cycle
  always_comb begin
    case (op_i)
      lcop_pkg::MAC_LOAD: acc_d = prod_q;
      lcop_pkg::MAC_ADD:  acc_d = acc_q + prod_q;
      lcop_pkg::MAC_SUB:  acc_d = acc_q - prod_q;
      default:            acc_d = acc_q;
    endcase
  end

  // product and accumulator registers
  always_ff @(posedge clk_i) begin
    prod_q <= lcop_pkg::PROD_W'(a_i) * lcop_pkg::PROD_W'(b_i);
    acc_q  <= acc_d;
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

>>> sv/lcop_scale.sv
// lcop_scale: block scaling of a three component vector to a peak magnitude in [2^22, 2^23-1]
// depends on lcop_pkg
module lcop_scale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lcop_pkg::wide_t   vec_i [3],
  output logic              done_o,
  output logic              zero_o,
  output lcop_pkg::narrow_t vec_o [3]
);

  localparam logic [lcop_pkg::WIDE_W-1:0] HI_LIM  = lcop_pkg::WIDE_W'(24'h7FFFFF);
  localparam logic [lcop_pkg::WIDE_W-1:0] LO_LIM  = lcop_pkg::WIDE_W'(24'h400000);
  localparam logic [lcop_pkg::WIDE_W-1:0] LO8_LIM = lcop_pkg::WIDE_W'(24'h004000);

  function automatic logic [lcop_pkg::WIDE_W-1:0] mag(input lcop_pkg::wide_t v);
    logic [lcop_pkg::WIDE_W-1:0] r;
    r = v[lcop_pkg::WIDE_W-1] ? lcop_pkg::WIDE_W'(-v) : lcop_pkg::WIDE_W'(v);
    return r;
  endfunction

  function automatic logic [lcop_pkg::WIDE_W-1:0] peak(input lcop_pkg::wide_t a,
                                                       input lcop_pkg::wide_t b,
                                                       input lcop_pkg::wide_t c);
    logic [lcop_pkg::WIDE_W-1:0] m;
    m = mag(a);
    if (mag(b) > m) m = mag(b);
    if (mag(c) > m) m = mag(c);
    return m;
  endfunction

  logic                        busy_q;
  lcop_pkg::wide_t             v_q [3];
  lcop_pkg::wide_t             v_d [3];
  lcop_pkg::wide_t             v_r8 [3];
  logic [lcop_pkg::WIDE_W-1:0] m, m8;
  logic                        finish;

  // one shift step: by eight where it cannot overshoot, else by one
  always_comb begin
    for (int i = 0; i < 3; i++) v_r8[i] = v_q[i] >>> 8;
    m      = peak(v_q[0], v_q[1], v_q[2]);
    m8     = peak(v_r8[0], v_r8[1], v_r8[2]);
    finish = (m == '0) || ((m <= HI_LIM) && (m >= LO_LIM));
    for (int i = 0; i < 3; i++) begin
      if (m > HI_LIM) begin
        v_d[i] = (m8 > HI_LIM) ? v_r8[i] : (v_q[i] >>> 1);
      end else if (m < LO8_LIM) begin
        v_d[i] = v_q[i] <<< 8;
      end else begin
        v_d[i] = v_q[i] <<< 1;
      end
    end
  end

  // busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && finish) begin
      busy_q <= 1'b0;
    end
  end

  // working vector
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= vec_i;
    end else if (busy_q && !finish) begin
      v_q <= v_d;
    end
  end

  assign done_o = busy_q && finish;
  assign zero_o = (m == '0);

  always_comb begin
    for (int i = 0; i < 3; i++) vec_o[i] = v_q[i][lcop_pkg::NARROW_W-1:0];
  end

endmodule

>>> sv/lcop_div.sv
// lcop_div: restoring divider for floor(num * 2^16 / den) with num <= den, one bit a cycle
// depends on lcop_pkg
module lcop_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  lcop_pkg::sq_t    num_i,
  input  lcop_pkg::sq_t    den_i,
  output logic             done_o,
  output lcop_pkg::ratio_t quot_o
);

  localparam int unsigned CNT_W = $clog2(lcop_pkg::RATIO_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(lcop_pkg::RATIO_W - 1);

  logic                      busy_q, done_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [lcop_pkg::SQ_W:0]   rem_q, rem_d, diff;
  lcop_pkg::sq_t             den_q;
  lcop_pkg::ratio_t          quot_q, quot_d;
  logic                      ge;

  // compare, subtract, shift
  always_comb begin
    ge     = rem_q >= {1'b0, den_q};
    diff   = ge ? (rem_q - {1'b0, den_q}) : rem_q;
    quot_d = {quot_q[lcop_pkg::RATIO_W-2:0], ge};
    rem_d  = {diff[lcop_pkg::SQ_W-1:0], 1'b0};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_LAST;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> sv/lcop_accum.sv
// lcop_accum: per chain and position saturating sums of S_CD and S_CD^2
// depends on lcop_pkg; holds both accumulator memories and their valid bits
module lcop_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcop_pkg::acc_req_t req_i,
  output lcop_pkg::acc_rsp_t rsp_o
);

  localparam lcop_pkg::sum_t   SUM_MAX   = {1'b0, {(lcop_pkg::SUM_W-1){1'b1}}};
  localparam lcop_pkg::sum_t   SUM_MIN   = {1'b1, {(lcop_pkg::SUM_W-1){1'b0}}};
  localparam lcop_pkg::sumsq_t SUMSQ_MAX = '1;

  lcop_pkg::sum_t   sum_mem [lcop_pkg::ACC_DEPTH];
  lcop_pkg::sumsq_t sq_mem  [lcop_pkg::ACC_DEPTH];
  logic [lcop_pkg::ACC_DEPTH-1:0] vld_q;

  logic               pend_q, done_q, hit_q, rng_q;
  lcop_pkg::idx_t     idx_q;
  lcop_pkg::order_t   s_q;
  lcop_pkg::sqr_t     sq_q;
  lcop_pkg::sum_t     rd_sum_q, sum_q, new_sum, old_sum;
  lcop_pkg::sumsq_t   rd_sq_q, sumsq_q, new_sq, old_sq;
  logic signed [lcop_pkg::SUM_W:0] sum_w;
  logic [lcop_pkg::SUMSQ_W:0]      sq_w;

  // saturating update of the entry read in the previous cycle
  always_comb begin
    old_sum = hit_q ? rd_sum_q : '0;
    old_sq  = hit_q ? rd_sq_q : '0;
    sum_w   = (lcop_pkg::SUM_W+1)'(old_sum) + (lcop_pkg::SUM_W+1)'(s_q);
    if (sum_w > (lcop_pkg::SUM_W+1)'(SUM_MAX)) begin
      new_sum = SUM_MAX;
    end else if (sum_w < (lcop_pkg::SUM_W+1)'(SUM_MIN)) begin
      new_sum = SUM_MIN;
    end else begin
      new_sum = sum_w[lcop_pkg::SUM_W-1:0];
    end
    sq_w   = {1'b0, old_sq} + (lcop_pkg::SUMSQ_W+1)'(sq_q);
    new_sq = sq_w[lcop_pkg::SUMSQ_W] ? SUMSQ_MAX : sq_w[lcop_pkg::SUMSQ_W-1:0];
  end

  // control and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      done_q <= 1'b0;
      vld_q  <= '0;
    end else begin
      pend_q <= req_i.start;
      done_q <= pend_q;
      if (pend_q && rng_q) vld_q[idx_q] <= 1'b1;
    end
  end

  // memory read, write and result registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rd_sum_q <= sum_mem[req_i.idx];
      rd_sq_q  <= sq_mem[req_i.idx];
      hit_q    <= vld_q[req_i.idx];
      idx_q    <= req_i.idx;
      rng_q    <= req_i.in_range;
      s_q      <= req_i.s;
      sq_q     <= req_i.sq;
    end
    if (pend_q) begin
      if (rng_q) begin
        sum_mem[idx_q] <= new_sum;
        sq_mem[idx_q]  <= new_sq;
      end
      sum_q   <= rng_q ? new_sum : '0;
      sumsq_q <= rng_q ? new_sq : '0;
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.sum   = sum_q;
  assign rsp_o.sumsq = sumsq_q;

endmodule

>>> sv/lipid_chain_order_parameter_top.sv
// lipid_chain_order_parameter_top: S_CD order parameter with per position accumulators
// depends on lcop_pkg, lcop_mac, lcop_scale, lcop_div, lcop_accum
// The work per input runs through five scaling passes, two cross products and two divides on
// the shared multiplier and divider, and ends early for a degenerate frame; a new input is
// taken only after the previous result has been loaded into the output register.
// Input ready only while the sequencer idles. Reset: axis z, accumulators read zero until written.
module lipid_chain_order_parameter_top (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [31:0]      prev_x_i,
  input  logic signed [31:0]      prev_y_i,
  input  logic signed [31:0]      prev_z_i,
  input  logic signed [31:0]      cur_x_i,
  input  logic signed [31:0]      cur_y_i,
  input  logic signed [31:0]      cur_z_i,
  input  logic signed [31:0]      next_x_i,
  input  logic signed [31:0]      next_y_i,
  input  logic signed [31:0]      next_z_i,
  input  logic                    chain_select_i,
  input  logic [5:0]              position_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [15:0]      order_value_o,
  output logic signed [31:0]      running_sum_o,
  output logic [47:0]             running_sum_sq_o,
  output logic                    degenerate_o
);

  localparam int unsigned UW = lcop_pkg::PROD_W + 1;
  localparam logic signed [UW-1:0] ROUND_OFS = UW'(262144);
  localparam logic signed [UW-1:0] S_MAX     = UW'(32767);
  localparam logic signed [UW-1:0] S_MIN     = -UW'(32768);
  localparam lcop_pkg::p2_t        P2_OFS    = lcop_pkg::P2_W'(65536);

  lcop_pkg::state_e  state_q, state_d;
  lcop_pkg::vsel_e   vsel_q;
  logic [lcop_pkg::STEP_W-1:0] step_q;
  lcop_pkg::axis_t   axis_q, ax;

  lcop_pkg::coord_t  in_p [3], in_c [3], in_n [3];
  lcop_pkg::coord_t  p_q [3], c_q [3], n_q [3];
  logic              chain_q;
  logic [lcop_pkg::POS_W-1:0] pos_q;

  lcop_pkg::wide_t   raw_q [3];
  lcop_pkg::wide_t   scl_vec [3];
  lcop_pkg::narrow_t scl_out [3];
  lcop_pkg::narrow_t sz_q [3], fwd_q [3], bck_q [3], sx_q [3], sy_q [3];
  lcop_pkg::narrow_t va [3], vb [3], vn [3];
  logic              degen_q;
  lcop_pkg::sq_t     a2_q;
  lcop_pkg::ratio_t  rx_q, ry_q, quot;
  lcop_pkg::p2_t     qx, qy;
  lcop_pkg::order_t  s_q, s_d;
  logic signed [UW-1:0] u, sf;

  lcop_pkg::mac_op_e mac_op;
  lcop_pkg::opnd_t   mul_a, mul_b;
  lcop_pkg::prod_t   prod, acc;
  logic              scl_start, scl_done, scl_zero;
  logic              div_start, div_done;
  lcop_pkg::acc_req_t acc_req;
  lcop_pkg::acc_rsp_t acc_rsp;

  lcop_pkg::sum_t    res_sum_q;
  lcop_pkg::sumsq_t  res_sumsq_q;
  logic              out_valid_q;
  logic              load_out;

  // input vectors and axis select
  always_comb begin
    in_p[0] = prev_x_i; in_p[1] = prev_y_i; in_p[2] = prev_z_i;
    in_c[0] = cur_x_i;  in_c[1] = cur_y_i;  in_c[2] = cur_z_i;
    in_n[0] = next_x_i; in_n[1] = next_y_i; in_n[2] = next_z_i;
    ax = (axis_q >= lcop_pkg::AXIS_Z) ? lcop_pkg::AXIS_Z : axis_q;
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= lcop_pkg::AXIS_RESET;
    end else if (cfg_we_i) begin
      axis_q <= cfg_wdata_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcop_pkg::ST_IDLE:  if (in_valid_i) state_d = lcop_pkg::ST_SCALE;
      lcop_pkg::ST_SCALE: begin
        if (scl_done) begin
          if (scl_zero) begin
            state_d = lcop_pkg::ST_TERM;
          end else if (vsel_q == lcop_pkg::VS_BCK || vsel_q == lcop_pkg::VS_SX) begin
            state_d = lcop_pkg::ST_CROSS;
          end else if (vsel_q == lcop_pkg::VS_SY) begin
            state_d = lcop_pkg::ST_NORM;
          end
        end
      end
      lcop_pkg::ST_CROSS: if (step_q == 3'd7) state_d = lcop_pkg::ST_SCALE;
      lcop_pkg::ST_NORM:  if (step_q == 3'd4) state_d = lcop_pkg::ST_DIV;
      lcop_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = (vsel_q == lcop_pkg::VS_SX) ? lcop_pkg::ST_NORM : lcop_pkg::ST_TERM;
        end
      end
      lcop_pkg::ST_TERM:  if (step_q == 3'd5) state_d = lcop_pkg::ST_ACC;
      lcop_pkg::ST_ACC:   if (acc_rsp.done) state_d = lcop_pkg::ST_DONE;
      lcop_pkg::ST_DONE:  if (!out_valid_q || out_ready_i) state_d = lcop_pkg::ST_IDLE;
      default:            state_d = lcop_pkg::ST_IDLE;
    endcase
  end

  // P2 terms and clamped result
  always_comb begin
    qx = lcop_pkg::P2_W'({rx_q, 1'b0}) + lcop_pkg::P2_W'(rx_q) - P2_OFS;
    qy = lcop_pkg::P2_W'({ry_q, 1'b0}) + lcop_pkg::P2_W'(ry_q) - P2_OFS;
    u  = ROUND_OFS - UW'(acc);
    sf = u >>> 19;
    if (degen_q) begin
      s_d = '0;
    end else if (sf > S_MAX) begin
      s_d = S_MAX[lcop_pkg::ORDER_W-1:0];
    end else if (sf < S_MIN) begin
      s_d = S_MIN[lcop_pkg::ORDER_W-1:0];
    end else begin
      s_d = sf[lcop_pkg::ORDER_W-1:0];
    end
  end

  // operand vectors for cross product and norm
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = (vsel_q == lcop_pkg::VS_SX) ? fwd_q[i] : sz_q[i];
      vb[i] = (vsel_q == lcop_pkg::VS_SX) ? bck_q[i] : sx_q[i];
      vn[i] = (vsel_q == lcop_pkg::VS_SX) ? sx_q[i] : sy_q[i];
    end
  end

  // sequencer outputs
  always_comb begin
    mac_op    = lcop_pkg::MAC_NONE;
    mul_a     = '0;
    mul_b     = '0;
    scl_start = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    for (int i = 0; i < 3; i++) scl_vec[i] = '0;
    unique case (state_q)
      lcop_pkg::ST_IDLE: begin
        scl_start = in_valid_i;
        for (int i = 0; i < 3; i++) begin
          scl_vec[i] = lcop_pkg::WIDE_W'(in_n[i]) - lcop_pkg::WIDE_W'(in_p[i]);
        end
      end
      lcop_pkg::ST_SCALE: begin
        scl_start = scl_done && !scl_zero &&
                    (vsel_q == lcop_pkg::VS_SZ || vsel_q == lcop_pkg::VS_FWD);
        for (int i = 0; i < 3; i++) begin
          scl_vec[i] = (vsel_q == lcop_pkg::VS_SZ)
                     ? lcop_pkg::WIDE_W'(n_q[i]) - lcop_pkg::WIDE_W'(c_q[i])
                     : lcop_pkg::WIDE_W'(p_q[i]) - lcop_pkg::WIDE_W'(c_q[i]);
        end
      end
      lcop_pkg::ST_CROSS: begin
        scl_vec[0] = raw_q[0];
        scl_vec[1] = raw_q[1];
        scl_vec[2] = lcop_pkg::WIDE_W'(acc);
        scl_start  = (step_q == 3'd7);
        case (step_q)
          3'd0: begin mul_a = lcop_pkg::OPND_W'(va[1]); mul_b = lcop_pkg::OPND_W'(vb[2]); end
          3'd1: begin
            mul_a = lcop_pkg::OPND_W'(va[2]); mul_b = lcop_pkg::OPND_W'(vb[1]);
            mac_op = lcop_pkg::MAC_LOAD;
          end
          3'd2: begin
            mul_a = lcop_pkg::OPND_W'(va[2]); mul_b = lcop_pkg::OPND_W'(vb[0]);
            mac_op = lcop_pkg::MAC_SUB;
          end
          3'd3: begin
            mul_a = lcop_pkg::OPND_W'(va[0]); mul_b = lcop_pkg::OPND_W'(vb[2]);
            mac_op = lcop_pkg::MAC_LOAD;
          end
          3'd4: begin
            mul_a = lcop_pkg::OPND_W'(va[0]); mul_b = lcop_pkg::OPND_W'(vb[1]);
            mac_op = lcop_pkg::MAC_SUB;
          end
          3'd5: begin
            mul_a = lcop_pkg::OPND_W'(va[1]); mul_b = lcop_pkg::OPND_W'(vb[0]);
            mac_op = lcop_pkg::MAC_LOAD;
          end
          3'd6: mac_op = lcop_pkg::MAC_SUB;
          default: mac_op = lcop_pkg::MAC_NONE;
        endcase
      end
      lcop_pkg::ST_NORM: begin
        div_start = (step_q == 3'd4);
        case (step_q)
          3'd0: begin mul_a = lcop_pkg::OPND_W'(vn[0]); mul_b = lcop_pkg::OPND_W'(vn[0]); end
          3'd1: begin
            mul_a = lcop_pkg::OPND_W'(vn[1]); mul_b = lcop_pkg::OPND_W'(vn[1]);
            mac_op = lcop_pkg::MAC_LOAD;
          end
          3'd2: begin
            mul_a = lcop_pkg::OPND_W'(vn[2]); mul_b = lcop_pkg::OPND_W'(vn[2]);
            mac_op = lcop_pkg::MAC_ADD;
          end
          3'd3: mac_op = lcop_pkg::MAC_ADD;
          default: mac_op = lcop_pkg::MAC_NONE;
        endcase
      end
      lcop_pkg::ST_DIV: mac_op = lcop_pkg::MAC_NONE;
      lcop_pkg::ST_TERM: begin
        case (step_q)
          3'd0: begin mul_a = lcop_pkg::K_X; mul_b = lcop_pkg::OPND_W'(qx); end
          3'd1: begin
            mul_a = lcop_pkg::K_Y; mul_b = lcop_pkg::OPND_W'(qy);
            mac_op = lcop_pkg::MAC_LOAD;
          end
          3'd2: mac_op = lcop_pkg::MAC_ADD;
          3'd4: begin mul_a = lcop_pkg::OPND_W'(s_q); mul_b = lcop_pkg::OPND_W'(s_q); end
          default: mac_op = lcop_pkg::MAC_NONE;
        endcase
      end
      lcop_pkg::ST_ACC:  mac_op = lcop_pkg::MAC_NONE;
      lcop_pkg::ST_DONE: load_out = !out_valid_q || out_ready_i;
      default: mac_op = lcop_pkg::MAC_NONE;
    endcase
  end

  // accumulator request
  always_comb begin
    acc_req.start    = (state_q == lcop_pkg::ST_TERM) && (step_q == 3'd5);
    acc_req.in_range = int'(pos_q) < lcop_pkg::MAX_POSITIONS;
    acc_req.idx      = lcop_pkg::IDX_W'(int'(chain_q) * lcop_pkg::MAX_POSITIONS + int'(pos_q));
    acc_req.s        = s_q;
    acc_req.sq       = prod[lcop_pkg::SQR_W-1:0];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcop_pkg::ST_IDLE;
      step_q      <= '0;
      vsel_q      <= lcop_pkg::VS_SZ;
      degen_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= (state_d != state_q) ? '0 : step_q + 1'b1;
      if (state_q == lcop_pkg::ST_IDLE && in_valid_i) begin
        vsel_q  <= lcop_pkg::VS_SZ;
        degen_q <= 1'b0;
      end
      if (state_q == lcop_pkg::ST_SCALE && scl_done) begin
        if (scl_zero) begin
          degen_q <= 1'b1;
        end else begin
          unique case (vsel_q)
            lcop_pkg::VS_SZ:  vsel_q <= lcop_pkg::VS_FWD;
            lcop_pkg::VS_FWD: vsel_q <= lcop_pkg::VS_BCK;
            lcop_pkg::VS_BCK: vsel_q <= lcop_pkg::VS_SX;
            lcop_pkg::VS_SX:  vsel_q <= lcop_pkg::VS_SY;
            default:          vsel_q <= lcop_pkg::VS_SX;
          endcase
        end
      end
      if (state_q == lcop_pkg::ST_DIV && div_done && vsel_q == lcop_pkg::VS_SX) begin
        vsel_q <= lcop_pkg::VS_SY;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == lcop_pkg::ST_IDLE && in_valid_i) begin
      p_q     <= in_p;
      c_q     <= in_c;
      n_q     <= in_n;
      chain_q <= chain_select_i;
      pos_q   <= position_i;
    end
    if (state_q == lcop_pkg::ST_SCALE && scl_done && !scl_zero) begin
      unique case (vsel_q)
        lcop_pkg::VS_SZ:  sz_q  <= scl_out;
        lcop_pkg::VS_FWD: fwd_q <= scl_out;
        lcop_pkg::VS_BCK: bck_q <= scl_out;
        lcop_pkg::VS_SX:  sx_q  <= scl_out;
        default:          sy_q  <= scl_out;
      endcase
    end
    if (state_q == lcop_pkg::ST_CROSS && step_q == 3'd3) raw_q[0] <= lcop_pkg::WIDE_W'(acc);
    if (state_q == lcop_pkg::ST_CROSS && step_q == 3'd5) raw_q[1] <= lcop_pkg::WIDE_W'(acc);
    if (state_q == lcop_pkg::ST_NORM && step_q == lcop_pkg::STEP_W'(ax) + 1'b1) begin
      a2_q <= prod[lcop_pkg::SQ_W-1:0];
    end
    if (state_q == lcop_pkg::ST_DIV && div_done) begin
      if (vsel_q == lcop_pkg::VS_SX) rx_q <= quot;
      else                           ry_q <= quot;
    end
    if (state_q == lcop_pkg::ST_TERM && step_q == 3'd3) s_q <= s_d;
    if (acc_rsp.done) begin
      res_sum_q   <= acc_rsp.sum;
      res_sumsq_q <= acc_rsp.sumsq;
    end
    if (load_out) begin
      order_value_o    <= s_q;
      running_sum_o    <= res_sum_q;
      running_sum_sq_o <= res_sumsq_q;
      degenerate_o     <= degen_q;
    end
  end

  // shared units
  lcop_mac u_mac (
    .clk_i  (clk_i),
    .op_i   (mac_op),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod),
    .acc_o  (acc)
  );

  lcop_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scl_start),
    .vec_i   (scl_vec),
    .done_o  (scl_done),
    .zero_o  (scl_zero),
    .vec_o   (scl_out)
  );

  lcop_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (a2_q),
    .den_i   (acc[lcop_pkg::SQ_W-1:0]),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  lcop_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (acc_req),
    .rsp_o  (acc_rsp)
  );

  assign in_ready_o  = (state_q == lcop_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  // a degenerate frame always reports zero
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> order_value_o == '0)
    else $error("degenerate result with nonzero order value");

  // an input transfer starts the scaling pass
  a_accept_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == lcop_pkg::ST_SCALE)
    else $error("input transfer did not start scaling");

  // unit completions arrive only in their own states
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == lcop_pkg::ST_DIV)
    else $error("divider finished outside divide state");

  a_acc_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_rsp.done |-> state_q == lcop_pkg::ST_ACC)
    else $error("accumulator finished outside accumulate state");

  a_scale_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scl_done |-> state_q == lcop_pkg::ST_SCALE)
    else $error("scaler finished outside scale state");

endmodule

>>> test/lipid_chain_order_parameter_top_test.sv
// lipid_chain_order_parameter_top_test: self-checking bench for the S_CD order parameter block
// depends on lcop_pkg and lipid_chain_order_parameter_top; a queue-fed driver and a
// clocked monitor compare every result with an in-bench predictor of frame and accumulators
module lipid_chain_order_parameter_top_test;
  import lcop_pkg::*;

  typedef struct {
    coord_t      pt[9];   // prev xyz, cur xyz, next xyz
    logic        chain;
    logic [5:0]  pos;
  } carbon_t;

  typedef struct {
    order_t order;
    sum_t   sum;
    sumsq_t sumsq;
    logic   degen;
  } order_result_t;

  localparam longint unsigned SUMSQ_LIMIT = 48'hFFFF_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  coord_t prev_x_i = '0, prev_y_i = '0, prev_z_i = '0;
  coord_t cur_x_i = '0, cur_y_i = '0, cur_z_i = '0;
  coord_t next_x_i = '0, next_y_i = '0, next_z_i = '0;
  logic chain_select_i = 1'b0;
  logic [5:0] position_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  order_t order_value_o;
  sum_t running_sum_o;
  sumsq_t running_sum_sq_o;
  logic degenerate_o;

  carbon_t       pending_carbons[$];
  order_result_t expected_orders[$];
  axis_t         model_axis = AXIS_RESET;
  sum_t          model_sum[2*MAX_POSITIONS];
  sumsq_t        model_sumsq[2*MAX_POSITIONS];
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  bit            hold_for_drain = 1'b0;
  int            fail_count = 0;

  lipid_chain_order_parameter_top DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o,
    .prev_x_i, .prev_y_i, .prev_z_i, .cur_x_i, .cur_y_i, .cur_z_i,
    .next_x_i, .next_y_i, .next_z_i, .chain_select_i, .position_i,
    .out_valid_o, .out_ready_i,
    .order_value_o, .running_sum_o, .running_sum_sq_o, .degenerate_o
  );

  always #10 clk_i = ~clk_i;

  function automatic longint vec_max_mag(longint v[3]);
    longint m;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      if ((v[i] < 0 ? -v[i] : v[i]) > m) m = v[i] < 0 ? -v[i] : v[i];
    end
    return m;
  endfunction

  // block scaling into [2^22, 2^23-1]; returns 0 for an all-zero vector
  function automatic bit normalize_vec(inout longint v[3]);
    longint m;
    m = vec_max_mag(v);
    if (m == 0) return 1'b0;
    while (m > 64'h7F_FFFF) begin
      for (int i = 0; i < 3; i++) v[i] = v[i] >>> 1;
      m = vec_max_mag(v);
    end
    while (m < 64'h40_0000) begin
      for (int i = 0; i < 3; i++) v[i] = v[i] * 2;
      m = m * 2;
    end
    return 1'b1;
  endfunction

  function automatic void cross_prod(longint a[3], longint b[3], output longint c[3]);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // squared direction cosine on the axis, Q16
  function automatic longint dir_cos2(longint v[3], int ax);
    longint unsigned n2, a2;
    n2 = 0;
    for (int i = 0; i < 3; i++) n2 += longint'(v[i] * v[i]);
    a2 = v[ax] * v[ax];
    if (n2 == 0) return 0;
    return longint'((a2 << 16) / n2);
  endfunction

  // frame construction, S_CD and accumulator update for one carbon
  function automatic order_result_t predict_order(carbon_t c);
    longint fwd[3], bck[3], sz[3], sx[3], sy[3];
    longint qx, qy, t, s, sum;
    longint unsigned sq, acc;
    int ax;
    int idx;
    bit degen;
    order_result_t r;
    ax = (model_axis == AXIS_X) ? 0 : (model_axis == AXIS_Y) ? 1 : 2;
    for (int i = 0; i < 3; i++) begin
      fwd[i] = longint'(c.pt[6+i]) - longint'(c.pt[3+i]);
      bck[i] = longint'(c.pt[i]) - longint'(c.pt[3+i]);
      sz[i]  = longint'(c.pt[6+i]) - longint'(c.pt[i]);
    end
    degen = 1'b0;
    s = 0;
    if (!normalize_vec(sz) || !normalize_vec(fwd) || !normalize_vec(bck)) begin
      degen = 1'b1;
    end else begin
      cross_prod(fwd, bck, sx);
      if (!normalize_vec(sx)) begin
        degen = 1'b1;
      end else begin
        cross_prod(sz, sx, sy);
        if (!normalize_vec(sy)) degen = 1'b1;
      end
    end
    if (!degen) begin
      qx = 3 * dir_cos2(sx, ax) - 65536;
      qy = 3 * dir_cos2(sy, ax) - 65536;
      t = 43693 * qx + 21823 * qy;
      s = ((64'sd1 <<< 18) - t) >>> 19;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
    end
    r.order = order_t'(s);
    r.degen = degen;
    // position field cannot exceed the table with 64 positions
    idx = int'(c.chain) * MAX_POSITIONS + int'(c.pos);
    sum = longint'(model_sum[idx]) + s;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    model_sum[idx] = sum_t'(sum);
    sq = longint'(s * s);
    acc = model_sumsq[idx];
    acc = (acc > SUMSQ_LIMIT - sq) ? SUMSQ_LIMIT : acc + sq;
    model_sumsq[idx] = sumsq_t'(acc);
    r.sum = model_sum[idx];
    r.sumsq = model_sumsq[idx];
    return r;
  endfunction

  // driver: present pending carbons, predict on each input transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_orders.push_back(predict_order('{
          pt: '{prev_x_i, prev_y_i, prev_z_i, cur_x_i, cur_y_i, cur_z_i,
                next_x_i, next_y_i, next_z_i},
          chain: chain_select_i, pos: position_i}));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_carbons.size() > 0 && !(hold_for_drain && expected_orders.size() > 0)
            && !(in_valid_i && hold_for_drain)
            && $urandom_range(99) >= send_idle_pct) begin
          carbon_t c;
          c = pending_carbons.pop_front();
          {prev_x_i, prev_y_i, prev_z_i} <= {c.pt[0], c.pt[1], c.pt[2]};
          {cur_x_i, cur_y_i, cur_z_i}    <= {c.pt[3], c.pt[4], c.pt[5]};
          {next_x_i, next_y_i, next_z_i} <= {c.pt[6], c.pt[7], c.pt[8]};
          chain_select_i <= c.chain;
          position_i <= c.pos;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: check each output transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_orders.size() == 0) begin
          $error("unexpected result order_value %0d", order_value_o);
          fail_count++;
        end else begin
          order_result_t e;
          e = expected_orders.pop_front();
          if (order_value_o !== e.order) begin
            $error("order_value expected %0d got %0d", e.order, order_value_o);
            fail_count++;
          end
          if (running_sum_o !== e.sum) begin
            $error("running_sum expected %0d got %0d", e.sum, running_sum_o);
            fail_count++;
          end
          if (running_sum_sq_o !== e.sumsq) begin
            $error("running_sum_sq expected %0d got %0d", e.sumsq, running_sum_sq_o);
            fail_count++;
          end
          if (degenerate_o !== e.degen) begin
            $error("degenerate expected %0b got %0b", e.degen, degenerate_o);
            fail_count++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic carbon_t make_carbon(coord_t p[3], coord_t c[3], coord_t n[3],
                                          logic chain, logic [5:0] pos);
    carbon_t k;
    for (int i = 0; i < 3; i++) begin
      k.pt[i] = p[i];
      k.pt[3+i] = c[i];
      k.pt[6+i] = n[i];
    end
    k.chain = chain;
    k.pos = pos;
    return k;
  endfunction

  // random carbon: mostly a chain segment with bond-sized steps, some collinear, some noise
  function automatic carbon_t random_carbon();
    coord_t p[3], c[3], n[3];
    int kind;
    int sh;
    logic [5:0] pos;
    kind = $urandom_range(99);
    sh = $urandom_range(22, 8);
    pos = ($urandom_range(3) == 0) ? 6'($urandom_range(3)) : 6'($urandom);
    for (int i = 0; i < 3; i++) begin
      c[i] = coord_t'($urandom);
      if (kind < 75) begin
        p[i] = c[i] + (int'($urandom_range(2 ** sh)) - 2 ** (sh - 1));
        n[i] = c[i] + (int'($urandom_range(2 ** sh)) - 2 ** (sh - 1));
      end else if (kind < 85) begin
        p[i] = c[i] - (int'($urandom_range(2 ** 18)) - 2 ** 17);
        n[i] = c[i] + (c[i] - p[i]) * int'($urandom_range(3));
      end else begin
        p[i] = coord_t'($urandom);
        n[i] = coord_t'($urandom);
      end
    end
    return make_carbon(p, c, n, 1'($urandom), pos);
  endfunction

  task automatic wait_drained();
    while (pending_carbons.size() > 0 || in_valid_i || expected_orders.size() > 0)
      @(posedge clk_i);
    repeat (160) @(posedge clk_i);
  endtask

  task automatic write_axis(axis_t a);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= a;
    model_axis = a;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  localparam coord_t CMAX = 32'sh7FFF_FFFF;
  localparam coord_t CMIN = -32'sh8000_0000;
  localparam coord_t BOND = 32'sd131072;

  // stimulus sequence
  initial begin
    axis_t axis_plan[6];
    for (int i = 0; i < 2 * MAX_POSITIONS; i++) begin
      model_sum[i] = '0;
      model_sumsq[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners under the reset axis
    pending_carbons.push_back(make_carbon('{CMAX, CMAX, CMAX}, '{CMIN, CMIN, CMIN},
                                          '{CMAX, CMAX, CMAX}, 1'b0, 6'd0));
    pending_carbons.push_back(make_carbon('{CMIN, CMIN, CMIN}, '{0, 0, 0},
                                          '{CMAX, CMAX, CMAX}, 1'b1, 6'd63));
    pending_carbons.push_back(make_carbon('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, 1'b0, 6'd63));
    pending_carbons.push_back(make_carbon('{CMAX, CMIN, 0}, '{0, CMAX, CMIN},
                                          '{CMIN, 0, CMAX}, 1'b1, 6'd0));
    pending_carbons.push_back(make_carbon('{CMIN, CMAX, CMIN}, '{CMAX, CMIN, CMAX},
                                          '{CMIN, CMIN, CMAX}, 1'b0, 6'd1));
    pending_carbons.push_back(make_carbon('{0, 0, 0}, '{BOND, 0, BOND},
                                          '{0, 0, 2 * BOND}, 1'b0, 6'd2));
    pending_carbons.push_back(make_carbon('{0, 0, 0}, '{BOND, 0, BOND},
                                          '{0, 0, 2 * BOND}, 1'b0, 6'd2));
    pending_carbons.push_back(make_carbon('{0, 0, 0}, '{0, BOND, BOND},
                                          '{0, 0, 2 * BOND}, 1'b1, 6'd2));
    pending_carbons.push_back(make_carbon('{0, 0, 0}, '{0, 0, 1}, '{0, 1, 1}, 1'b1, 6'd3));
    pending_carbons.push_back(make_carbon('{-1, -1, -1}, '{-1, -1, -1},
                                          '{-1, -1, -1}, 1'b1, 6'd4));
    wait_drained();

    // every axis code, including the one that falls back to z
    for (int a = 0; a < 4; a++) begin
      write_axis(axis_t'(a));
      pending_carbons.push_back(make_carbon('{0, 0, 0}, '{BOND, 0, BOND},
                                            '{0, 0, 2 * BOND}, 1'(a), 6'd10));
      pending_carbons.push_back(make_carbon('{0, 0, 0}, '{0, BOND, 0},
                                            '{BOND, BOND, BOND}, 1'(a), 6'd11));
      pending_carbons.push_back(random_carbon());
      wait_drained();
    end

    // random phases across idle mixes and axis settings
    axis_plan = '{AXIS_X, AXIS_Z, AXIS_Y, 2'd3, AXIS_Z, AXIS_X};
    for (int ph = 0; ph < 6; ph++) begin
      write_axis(axis_plan[ph]);
      send_idle_pct  = (ph == 1 || ph == 3) ? 81 : (ph == 4) ? 19 : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? 81 : (ph == 4) ? 19 : 0;
      hold_for_drain = (ph == 5);
      for (int i = 0; i < 255; i++) pending_carbons.push_back(random_carbon());
      wait_drained();
    end
    hold_for_drain = 1'b0;

    if (fail_count == 0) begin
      $display("lipid_chain_order_parameter_top test passed");
    end else begin
      $display("lipid_chain_order_parameter_top test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("lipid_chain_order_parameter_top test failed");
    $finish;
  end

endmodule

>>> lipid_chain_order_parameter_top.f
sv/lcop_pkg.sv
sv/lcop_mac.sv
sv/lcop_scale.sv
sv/lcop_div.sv
sv/lcop_accum.sv
sv/lipid_chain_order_parameter_top.sv
test/lipid_chain_order_parameter_top_test.sv
